// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the bit-field buffer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge outside reset.
`define BFRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define BFRW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/bfrw_pkg.sv =====
// ---------------------------------------------------------------------------
// bfrw_pkg
// Types, constants and helpers of the bit-field buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package bfrw_pkg;

  // Buffer geometry
  localparam int unsigned BUF_WORDS = 1024;
  localparam int unsigned BUF_AW    = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
  localparam int unsigned BUF_BITS  = BUF_WORDS * 32;
  // Hard ceiling of the usable length (cursor is 16 bits wide)
  localparam logic [15:0] LIM_CAP   = (BUF_BITS > 65535) ? 16'hFFFF : 16'(BUF_BITS);
  localparam logic [15:0] DATA_BITS_RST = LIM_CAP;
  localparam int unsigned SIGN_BIT  = 31;

  typedef logic [BUF_AW-1:0] addr_t;

  typedef enum logic [2:0] {
    REQ_WR_U  = 3'd0,
    REQ_WR_S  = 3'd1,
    REQ_RD_U  = 3'd2,
    REQ_RD_S  = 3'd3,
    REQ_SEEK  = 3'd4,
    REQ_CLEAR = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    WH_START = 2'd0,
    WH_CUR   = 2'd1,
    WH_END   = 2'd2,
    WH_BAD   = 2'd3
  } whence_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_SEEK = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_WRITE2,
    S_WAIT
  } state_e;

  // Ones in the low n bits, n in 0..32
  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [31:0] m;
    if (n[5]) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF << n[4:0]);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bfrw_req_if.sv =====
// ---------------------------------------------------------------------------
// bfrw_req_if
// Request channel of the bit-field buffer: valid/ready plus request fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface bfrw_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        value;
  logic [5:0]         num_bits;
  logic signed [17:0] position;
  logic [1:0]         whence;

  modport source (
    output valid, req_type, value, num_bits, position, whence,
    input  ready
  );

  modport sink (
    input  valid, req_type, value, num_bits, position, whence,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/bfrw_rsp_if.sv =====
// ---------------------------------------------------------------------------
// bfrw_rsp_if
// Response channel of the bit-field buffer: valid/ready plus result fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface bfrw_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic        overflow;
  logic [15:0] bit_position;

  modport source (
    output valid, read_value, status, overflow, bit_position,
    input  ready
  );

  modport sink (
    input  valid, read_value, status, overflow, bit_position,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/bit_field_buffer_read_write.sv =====
// ---------------------------------------------------------------------------
// bit_field_buffer_read_write
// LSB-first bit-field packer/unpacker over a word memory with a bit cursor.
// ---------------------------------------------------------------------------
// Usage:
//   req_i  : one request per handshake (write/read unsigned or signed field,
//            seek, clear). Taken when valid and ready are high at clk_i.
//   rsp_o  : exactly one response per request, in request order.
//   cfg_*  : usable buffer length in bits, written while the block is idle.
// Timing: the reads of the two words under the cursor are issued at acceptance;
//   the access state then merges and writes back the low word, and a write
//   that straddles a word boundary goes on to a state that writes the high
//   word through the single write port. The response is loaded from the
//   last of these states, or from a wait state while the output register is
//   full, and a new request is taken only once the block is back in idle.
// Reset: cursor and overflow flag clear, length 32768 bits. Buffer words
//   are undefined until written; there is no clearing pass.
// Stall: a finished response sits in the output register; the next request
//   is still taken and worked on, and its response waits inside until the
//   output register drains.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bit_field_buffer_read_write (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bfrw_req_if.sink         req_i,
  bfrw_rsp_if.source       rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  // ---------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------
  bfrw_pkg::state_e  state_q, state_d;
  logic [15:0]       cursor_q, cursor_d;
  logic              ovf_q, ovf_d;
  logic [15:0]       data_bits_q;
  logic              rsp_valid_q;

  // request context, captured at acceptance
  bfrw_pkg::addr_t   wa_q;
  logic [4:0]        off_q;
  logic [5:0]        wr_w_q;
  logic [31:0]       wr_field_q;
  logic [5:0]        rd_w_q;
  logic              sign_en_q;
  logic [4:0]        sign_rel_q;
  logic [4:0]        ext_sh_q;
  bfrw_pkg::status_e status_q, status_d;
  logic [31:0]       rd_q;
  logic [31:0]       hi_q;

  // output register payload
  logic [31:0]       out_rd_q;
  logic [1:0]        out_status_q;
  logic              out_ovf_q;
  logic [15:0]       out_pos_q;

  // memory
  logic [31:0]       mem_q [bfrw_pkg::BUF_WORDS];
  logic [31:0]       rdata0_q, rdata1_q;
  bfrw_pkg::addr_t   ra0, ra1;
  logic              mem_we;
  bfrw_pkg::addr_t   mem_wa;
  logic [31:0]       mem_wd;

  // control
  logic              req_acc;
  logic              out_free;
  logic              load_out;
  logic              load_now;
  bfrw_pkg::req_e    req_op;

  // decision logic
  logic [15:0]       lim;
  logic [5:0]        n_clamp, n_one, n1;
  logic              is_signed, is_read, is_write;
  logic              short_rd;
  logic [16:0]       sum1, sum2;
  logic              fit1, ovf1, sign_ok, first_acc, bad;
  logic [15:0]       c1, c2;
  logic [5:0]        wr_w;
  logic [31:0]       field;
  logic [15:0]       seek_base;
  logic [18:0]       seek_tgt;
  logic              seek_rej;

  // access cycle logic
  logic [63:0]       m64, v64, win, win_sh;
  logic [31:0]       lo_data, hi_data, mag, rd_val;
  logic              span;
  logic [5:0]        sidx;
  logic              sbit;

  assign req_acc  = req_i.valid && req_i.ready;
  assign req_op   = bfrw_pkg::req_e'(req_i.req_type);
  assign out_free = !rsp_valid_q || rsp_o.ready;

  // Effective length: configured length capped by buffer size
  assign lim = (data_bits_q > bfrw_pkg::LIM_CAP) ? bfrw_pkg::LIM_CAP : data_bits_q;

  // ---------------------------------------------------------------------
  // Request decode: fit checks, cursor and overflow outcome
  // ---------------------------------------------------------------------
  always_comb begin
    n_clamp   = (req_i.num_bits > 6'd32) ? 6'd32 : req_i.num_bits;
    is_signed = (req_op == bfrw_pkg::REQ_WR_S) || (req_op == bfrw_pkg::REQ_RD_S);
    is_read   = (req_op == bfrw_pkg::REQ_RD_U) || (req_op == bfrw_pkg::REQ_RD_S);
    is_write  = (req_op == bfrw_pkg::REQ_WR_U) || (req_op == bfrw_pkg::REQ_WR_S);
    n_one     = (n_clamp == 6'd0) ? 6'd1 : n_clamp;
    // signed: magnitude part is one bit shorter
    n1        = is_signed ? (n_one - 6'd1) : n_clamp;

    // byte read with fewer than 8 bits left skips its magnitude part
    short_rd  = is_read && (n1 == 6'd8) && (cursor_q <= lim) && ((lim - cursor_q) < 16'd8);

    sum1      = {1'b0, cursor_q} + {11'd0, n1};
    fit1      = sum1 <= {1'b0, lim};
    first_acc = !short_rd && fit1;
    c1        = short_rd ? cursor_q : (fit1 ? sum1[15:0] : lim);
    ovf1      = ovf_q || (!short_rd && !fit1);

    // sign-bit step
    sum2      = {1'b0, c1} + 17'd1;
    sign_ok   = is_signed && !ovf1 && (sum2 <= {1'b0, lim});
    c2        = sign_ok ? sum2[15:0] : c1;
    bad       = (!short_rd && !fit1) || (is_signed && !sign_ok);

    // merged write field: magnitude bits then the sign bit
    wr_w      = (is_write && first_acc) ? (n1 + {5'd0, sign_ok}) : 6'd0;
    field     = req_i.value & bfrw_pkg::low_mask(n1);
    if (is_signed) begin
      field = field | ({31'd0, req_i.value[bfrw_pkg::SIGN_BIT]} << n1[4:0]);
    end
    field     = field & bfrw_pkg::low_mask(wr_w);

    // seek target
    case (bfrw_pkg::whence_e'(req_i.whence))
      bfrw_pkg::WH_CUR: seek_base = cursor_q;
      bfrw_pkg::WH_END: seek_base = lim;
      default:          seek_base = 16'd0;
    endcase
    seek_tgt = {req_i.position[17], req_i.position} + {3'd0, seek_base};
    seek_rej = (bfrw_pkg::whence_e'(req_i.whence) == bfrw_pkg::WH_BAD) || seek_tgt[18]
               || (seek_tgt[17:0] > {2'd0, lim});
  end

  // ---------------------------------------------------------------------
  // Next cursor, flag and status per request type
  // ---------------------------------------------------------------------
  always_comb begin
    cursor_d = cursor_q;
    ovf_d    = ovf_q;
    status_d = bfrw_pkg::ST_OK;
    case (req_op)
      bfrw_pkg::REQ_WR_U, bfrw_pkg::REQ_WR_S, bfrw_pkg::REQ_RD_U, bfrw_pkg::REQ_RD_S: begin
        cursor_d = c2;
        ovf_d    = ovf1 || (is_signed && !sign_ok);
        status_d = bad ? bfrw_pkg::ST_OVF : bfrw_pkg::ST_OK;
      end
      bfrw_pkg::REQ_SEEK: begin
        if (seek_rej) begin
          status_d = bfrw_pkg::ST_SEEK;
        end else begin
          cursor_d = seek_tgt[15:0];
        end
      end
      bfrw_pkg::REQ_CLEAR: begin
        cursor_d = 16'd0;
        ovf_d    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Cursor, flag and length registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= 16'd0;
      ovf_q       <= 1'b0;
      data_bits_q <= bfrw_pkg::DATA_BITS_RST;
    end else begin
      if (req_acc) begin
        cursor_q <= cursor_d;
        ovf_q    <= ovf_d;
      end
      if (cfg_we_i) begin
        data_bits_q <= cfg_wdata_i;
      end
    end
  end

  // Request context for the access cycle
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      wa_q       <= ra0;
      off_q      <= cursor_q[4:0];
      wr_w_q     <= wr_w;
      wr_field_q <= field;
      rd_w_q     <= (is_read && first_acc) ? n1 : 6'd0;
      sign_en_q  <= (req_op == bfrw_pkg::REQ_RD_S) && sign_ok;
      sign_rel_q <= short_rd ? 5'd0 : n1[4:0];
      ext_sh_q   <= n1[4:0];
      status_q   <= status_d;
    end
  end

  // ---------------------------------------------------------------------
  // Word memory: both words under the cursor are read at acceptance
  // ---------------------------------------------------------------------
  assign ra0 = bfrw_pkg::addr_t'(cursor_q[15:5]);
  assign ra1 = bfrw_pkg::addr_t'(ra0 + 1'b1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (req_acc) begin
      rdata0_q <= mem_q[ra0];
      rdata1_q <= mem_q[ra1];
    end
  end

  // ---------------------------------------------------------------------
  // Access cycle: field extract and read-modify-write merge
  // ---------------------------------------------------------------------
  always_comb begin
    m64     = {32'd0, bfrw_pkg::low_mask(wr_w_q)} << off_q;
    v64     = {32'd0, wr_field_q} << off_q;
    lo_data = (rdata0_q & ~m64[31:0]) | v64[31:0];
    hi_data = (rdata1_q & ~m64[63:32]) | v64[63:32];
    span    = |m64[63:32];

    win     = {rdata1_q, rdata0_q};
    win_sh  = win >> off_q;
    mag     = win_sh[31:0] & bfrw_pkg::low_mask(rd_w_q);
    sidx    = {1'b0, off_q} + {1'b0, sign_rel_q};
    sbit    = win[sidx];
    rd_val  = mag;
    if (sign_en_q && sbit) begin
      rd_val = mag | (32'hFFFF_FFFF << ext_sh_q);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfrw_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = bfrw_pkg::S_ACCESS;
        end
      end
      bfrw_pkg::S_ACCESS: begin
        if (span) begin
          state_d = bfrw_pkg::S_WRITE2;
        end else if (out_free) begin
          state_d = bfrw_pkg::S_IDLE;
        end else begin
          state_d = bfrw_pkg::S_WAIT;
        end
      end
      bfrw_pkg::S_WRITE2, bfrw_pkg::S_WAIT: begin
        state_d = out_free ? bfrw_pkg::S_IDLE : bfrw_pkg::S_WAIT;
      end
      default: state_d = bfrw_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = wa_q;
    mem_wd      = lo_data;
    load_out    = 1'b0;
    load_now    = 1'b0;
    unique case (state_q)
      bfrw_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
      end
      bfrw_pkg::S_ACCESS: begin
        mem_we   = (wr_w_q != 6'd0);
        load_out = !span && out_free;
        load_now = 1'b1;
      end
      bfrw_pkg::S_WRITE2: begin
        mem_we   = 1'b1;
        mem_wa   = bfrw_pkg::addr_t'(wa_q + 1'b1);
        mem_wd   = hi_q;
        load_out = out_free;
      end
      bfrw_pkg::S_WAIT: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfrw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Read value and high word held past the access cycle
  always_ff @(posedge clk_i) begin
    if (state_q == bfrw_pkg::S_ACCESS) begin
      rd_q <= rd_val;
      hi_q <= hi_data;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rd_q     <= load_now ? rd_val : rd_q;
      out_status_q <= status_q;
      out_ovf_q    <= ovf_q;
      out_pos_q    <= cursor_q;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.read_value   = out_rd_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.overflow     = out_ovf_q;
  assign rsp_o.bit_position = out_pos_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BFRW_ASSERT(a_cursor_cap, cursor_q <= bfrw_pkg::LIM_CAP, "cursor beyond buffer")
  `BFRW_ASSERT(a_acc_next, req_acc |=> state_q == bfrw_pkg::S_ACCESS, "request not issued")
  `BFRW_ASSERT(a_wr2_order, state_q == bfrw_pkg::S_WRITE2 |-> $past(state_q) == bfrw_pkg::S_ACCESS, "high word write out of order")
  `BFRW_ASSERT(a_ovf_clear, $fell(ovf_q) |-> $past(req_acc && req_op == bfrw_pkg::REQ_CLEAR), "overflow cleared without clear request")

endmodule

`default_nettype wire

// ===== test/tb_bit_field_buffer_read_write.sv =====
// ---------------------------------------------------------------------------
// tb_bit_field_buffer_read_write
// Self-checking bench for the LSB-first bit-field buffer.
//
// The buffer is filled with random words first, so that every later read
// lands on written storage. A short table of requests follows, some of them
// with hand-worked responses. Then several phases of random requests run
// under different usable lengths and handshake pressure. Every response is
// checked against its hand-worked value or a cycle-free model of the buffer kept in this file.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bit_field_buffer_read_write;
  import bfrw_pkg::*;

  localparam logic [2:0]  REQ_SPARE_6     = 3'd6;
  localparam logic [2:0]  REQ_SPARE_7     = 3'd7;
  localparam logic [15:0] LEN_AFTER_RESET = 16'd32768;
  localparam int unsigned TAIL_CYCLES     = 4;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned WATCHDOG_CYCLES = 3000;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [31:0]        value;
    logic [5:0]         num_bits;
    logic signed [17:0] position;
    whence_e            whence;
  } req_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic        overflow;
    logic [15:0] bit_position;
  } rsp_item_t;

  typedef struct packed {
    bit        has_known;
    req_item_t rq;
    rsp_item_t known_rsp;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] len;
    int unsigned send_pct;
    int unsigned recv_pct;
    int unsigned items;
    bit          long_hold;
  } phase_t;

  // Directed requests, run right after the buffer is filled (cursor at end)
  localparam dir_row_t DIRECTED_ROWS [28] = '{
    '{1'b1, '{REQ_CLEAR, 32'h0, 6'd0, 18'sd0, WH_START}, '{32'h0, ST_OK, 1'b0, 16'd0}},
    '{1'b1, '{REQ_WR_U, 32'hFFFF_FFFF, 6'd32, 18'sd0, WH_START},
            '{32'h0, ST_OK, 1'b0, 16'd32}},
    '{1'b1, '{REQ_WR_U, 32'h0, 6'd0, 18'sd0, WH_START}, '{32'h0, ST_OK, 1'b0, 16'd32}},
    '{1'b1, '{REQ_WR_S, 32'h8000_0000, 6'd32, 18'sd0, WH_START},
            '{32'h0, ST_OK, 1'b0, 16'd64}},
    // signed width zero acts as a lone sign bit
    '{1'b1, '{REQ_WR_S, 32'h0000_0005, 6'd0, 18'sd0, WH_START},
            '{32'h0, ST_OK, 1'b0, 16'd65}},
    // widths above 32 clip to 32
    '{1'b1, '{REQ_WR_U, 32'hABCD_EF12, 6'd40, 18'sd0, WH_START},
            '{32'h0, ST_OK, 1'b0, 16'd97}},
    '{1'b1, '{REQ_WR_U, 32'h0000_013C, 6'd8, 18'sd0, WH_START},
            '{32'h0, ST_OK, 1'b0, 16'd105}},
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, 18'sd0, WH_START}, '{32'h0, ST_OK, 1'b0, 16'd0}},
    '{1'b1, '{REQ_RD_U, 32'h0, 6'd32, 18'sd0, WH_START},
            '{32'hFFFF_FFFF, ST_OK, 1'b0, 16'd32}},
    '{1'b1, '{REQ_RD_S, 32'h0, 6'd32, 18'sd0, WH_START},
            '{32'h8000_0000, ST_OK, 1'b0, 16'd64}},
    '{1'b1, '{REQ_RD_S, 32'h0, 6'd1, 18'sd0, WH_START}, '{32'h0, ST_OK, 1'b0, 16'd65}},
    '{1'b1, '{REQ_RD_U, 32'h0, 6'd63, 18'sd0, WH_START},
            '{32'hABCD_EF12, ST_OK, 1'b0, 16'd97}},
    '{1'b1, '{REQ_RD_S, 32'h0, 6'd8, 18'sd0, WH_START},
            '{32'h0000_003C, ST_OK, 1'b0, 16'd105}},
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, -18'sd8, WH_CUR}, '{32'h0, ST_OK, 1'b0, 16'd97}},
    '{1'b1, '{REQ_WR_S, 32'hFFFF_FFFF, 6'd8, 18'sd0, WH_START},
            '{32'h0, ST_OK, 1'b0, 16'd105}},
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, 18'sd97, WH_START}, '{32'h0, ST_OK, 1'b0, 16'd97}},
    '{1'b1, '{REQ_RD_S, 32'h0, 6'd8, 18'sd0, WH_START},
            '{32'hFFFF_FFFF, ST_OK, 1'b0, 16'd105}},
    // seek errors leave the cursor alone
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, -18'sd1, WH_START}, '{32'h0, ST_SEEK, 1'b0, 16'd105}},
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, 18'sd0, WH_BAD}, '{32'h0, ST_SEEK, 1'b0, 16'd105}},
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, 18'sd1, WH_END}, '{32'h0, ST_SEEK, 1'b0, 16'd105}},
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, -18'sd4, WH_END}, '{32'h0, ST_OK, 1'b0, 16'd32764}},
    // byte read with fewer than 8 bits left: zero, nothing moves
    '{1'b1, '{REQ_RD_U, 32'h0, 6'd8, 18'sd0, WH_START}, '{32'h0, ST_OK, 1'b0, 16'd32764}},
    '{1'b0, '{REQ_RD_S, 32'h0, 6'd9, 18'sd0, WH_START}, '0},
    '{1'b1, '{REQ_WR_U, 32'h0000_00FF, 6'd8, 18'sd0, WH_START},
            '{32'h0, ST_OVF, 1'b1, 16'd32768}},
    '{1'b1, '{REQ_WR_S, 32'h8000_0000, 6'd1, 18'sd0, WH_START},
            '{32'h0, ST_OVF, 1'b1, 16'd32768}},
    '{1'b1, '{REQ_SEEK, 32'h0, 6'd0, 18'sd0, WH_START}, '{32'h0, ST_OK, 1'b1, 16'd0}},
    // sticky overflow: sign step skipped, magnitude still written and read
    '{1'b1, '{REQ_WR_S, 32'h0000_0007, 6'd4, 18'sd0, WH_START},
            '{32'h0, ST_OVF, 1'b1, 16'd3}},
    '{1'b1, '{REQ_RD_S, 32'h0, 6'd4, 18'sd0, WH_START}, '{32'h7, ST_OVF, 1'b1, 16'd6}}
  };

  // Random phases: usable length, sender idle %, receiver stall %, items
  localparam phase_t PHASES [7] = '{
    '{16'd32768, 0,  0,  90, 1'b0},
    '{16'd0,     61, 0,  30, 1'b0},
    '{16'd65535, 0,  61, 90, 1'b1},
    '{16'd200,   15, 15, 90, 1'b0},
    '{16'd1000,  61, 0,  80, 1'b0},
    '{16'd40,    0,  61, 60, 1'b1},
    '{16'd33,    15, 15, 60, 1'b0}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  bfrw_req_if req_ch ();
  bfrw_rsp_if rsp_ch ();

  bit_field_buffer_read_write dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Buffer image and cursor state
  logic [31:0] buf_image [BUF_WORDS];
  int unsigned cursor_image   = 0;
  bit          overflow_image = 1'b0;
  logic [15:0] length_image   = LEN_AFTER_RESET;

  rsp_item_t   awaited_rsp_q [$];
  req_item_t   planned_reqs_q [$];

  // Request currently offered, with its hand-worked response if any
  req_item_t   cur_req;
  bit          cur_has_known;
  rsp_item_t   cur_known_rsp;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned err_count      = 0;

  // -------------------------------------------------------------------------
  // Buffer image helpers
  // -------------------------------------------------------------------------
  function automatic logic [31:0] ones_below(int unsigned n);
    if (n >= 32) return 32'hFFFF_FFFF;
    return (32'h1 << n) - 32'h1;
  endfunction

  function automatic int unsigned usable_bits();
    int unsigned cap;
    cap = BUF_WORDS * 32;
    if (32'(length_image) < cap) return 32'(length_image);
    return cap;
  endfunction

  function automatic void put_bits(int unsigned pos, logic [31:0] val, int unsigned n);
    int unsigned w, off;
    logic [63:0] m, v;
    w   = pos >> 5;
    off = pos & 31;
    if (n == 0) return;
    m = {32'h0, ones_below(n)} << off;
    v = {32'h0, val & ones_below(n)} << off;
    if (w < BUF_WORDS) buf_image[w] = (buf_image[w] & ~m[31:0]) | v[31:0];
    if (m[63:32] != 32'h0 && w + 1 < BUF_WORDS) begin
      buf_image[w+1] = (buf_image[w+1] & ~m[63:32]) | v[63:32];
    end
  endfunction

  function automatic logic [31:0] get_bits(int unsigned pos, int unsigned n);
    int unsigned w, off;
    logic [63:0] both;
    w    = pos >> 5;
    off  = pos & 31;
    both = '0;
    if (n == 0) return 32'h0;
    if (w < BUF_WORDS) both[31:0] = buf_image[w];
    if (off + n > 32 && w + 1 < BUF_WORDS) both[63:32] = buf_image[w+1];
    return 32'(both >> off) & ones_below(n);
  endfunction

  // Returns 1 when the field did not fit
  function automatic bit pack_field(logic [31:0] val, int unsigned n);
    int unsigned lim;
    lim = usable_bits();
    if (cursor_image + n > lim) begin
      overflow_image = 1'b1;
      cursor_image   = lim;
      return 1'b1;
    end
    put_bits(cursor_image, val, n);
    cursor_image += n;
    return 1'b0;
  endfunction

  function automatic bit unpack_field(int unsigned n, output logic [31:0] res);
    int unsigned lim;
    lim = usable_bits();
    res = 32'h0;
    // short byte read: quietly returns zero
    if (n == 8 && cursor_image <= lim && lim - cursor_image < 8) return 1'b0;
    if (cursor_image + n > lim) begin
      overflow_image = 1'b1;
      cursor_image   = lim;
      return 1'b1;
    end
    res = get_bits(cursor_image, n);
    cursor_image += n;
    return 1'b0;
  endfunction

  function automatic bit sign_step_skipped();
    if (cursor_image + 1 > usable_bits()) overflow_image = 1'b1;
    return overflow_image;
  endfunction

  // Applies one request to the image and returns the response it gives
  function automatic rsp_item_t predict_response(req_item_t rq);
    rsp_item_t   r;
    int unsigned n, lim;
    int          target;
    logic [31:0] mag;
    bit          bad, ok;
    r = '0;
    n = (rq.num_bits > 6'd32) ? 32 : 32'(rq.num_bits);
    case (rq.req_type)
      REQ_WR_U: begin
        if (pack_field(rq.value, n)) r.status = ST_OVF;
      end
      REQ_WR_S: begin
        if (n == 0) n = 1;
        bad = pack_field(rq.value, n - 1);
        if (sign_step_skipped()) begin
          bad = 1'b1;
        end else begin
          put_bits(cursor_image, {31'h0, rq.value[31]}, 1);
          cursor_image++;
        end
        if (bad) r.status = ST_OVF;
      end
      REQ_RD_U: begin
        if (unpack_field(n, mag)) r.status = ST_OVF;
        r.read_value = mag;
      end
      REQ_RD_S: begin
        if (n == 0) n = 1;
        bad = unpack_field(n - 1, mag);
        r.read_value = mag;
        if (sign_step_skipped()) begin
          bad = 1'b1;
        end else begin
          if (get_bits(cursor_image, 1) != 32'h0) r.read_value = mag - (32'h1 << (n - 1));
          cursor_image++;
        end
        if (bad) r.status = ST_OVF;
      end
      REQ_SEEK: begin
        lim    = usable_bits();
        target = $signed(rq.position);
        ok     = 1'b1;
        case (rq.whence)
          WH_CUR:  target += int'(cursor_image);
          WH_END:  target += int'(lim);
          WH_BAD:  ok = 1'b0;
          default: ;
        endcase
        if (!ok || target < 0 || target > int'(lim)) begin
          r.status = ST_SEEK;
        end else begin
          cursor_image = target;
        end
      end
      REQ_CLEAR: begin
        cursor_image   = 0;
        overflow_image = 1'b0;
      end
      default: ;
    endcase
    r.overflow     = overflow_image;
    r.bit_position = cursor_image[15:0];
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Random request planning
  // -------------------------------------------------------------------------
  function automatic req_item_t make_req(logic [2:0] kind, logic [31:0] val,
                                         int unsigned n, int pos, whence_e wh);
    req_item_t rq;
    rq.req_type = kind;
    rq.value    = val;
    rq.num_bits = 6'(n);
    rq.position = 18'(pos);
    rq.whence   = wh;
    return rq;
  endfunction

  function automatic int unsigned pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(63, 33);
    if (r < 22) return $urandom_range(9, 8);
    return $urandom_range(32);
  endfunction

  function automatic void plan_random_batch();
    int unsigned lim, spot, count, r;
    logic [2:0]  kinds  [4];
    int unsigned widths [4];
    logic [2:0]  kind;
    whence_e     wh;
    int          pos;
    lim = usable_bits();
    r   = $urandom_range(99);
    if (r < 55) begin
      // round trip: write a few fields, seek back, read them again
      spot  = $urandom_range(lim);
      count = $urandom_range(4, 1);
      planned_reqs_q.push_back(make_req(REQ_SEEK, $urandom, $urandom_range(63),
                                        int'(spot), WH_START));
      for (int i = 0; i < count; i++) begin
        kinds[i]  = ($urandom_range(1) != 0) ? REQ_WR_S : REQ_WR_U;
        widths[i] = pick_width();
        planned_reqs_q.push_back(make_req(kinds[i], $urandom, widths[i], $urandom,
                                          whence_e'($urandom_range(3))));
      end
      planned_reqs_q.push_back(make_req(REQ_SEEK, $urandom, $urandom_range(63),
                                        int'(spot), WH_START));
      for (int i = 0; i < count; i++) begin
        kind = (kinds[i] == REQ_WR_S) ? REQ_RD_S : REQ_RD_U;
        if ($urandom_range(9) == 0) kind = (kind == REQ_RD_S) ? REQ_RD_U : REQ_RD_S;
        planned_reqs_q.push_back(make_req(kind, $urandom, widths[i], $urandom,
                                          whence_e'($urandom_range(3))));
      end
    end else if (r < 75) begin
      // lone seek, mostly near the valid range
      wh = whence_e'($urandom_range(3));
      case (wh)
        WH_START: pos = $urandom_range(lim + 4);
        WH_CUR:   pos = int'($urandom_range(200)) - 100;
        WH_END:   pos = 4 - int'($urandom_range(lim + 4));
        default:  pos = $urandom_range(100);
      endcase
      if ($urandom_range(4) == 0) pos = $urandom;
      planned_reqs_q.push_back(make_req(REQ_SEEK, $urandom, $urandom_range(63), pos, wh));
    end else begin
      // anything at all
      planned_reqs_q.push_back(make_req(3'($urandom_range(7)), $urandom, pick_width(),
                                        $urandom, whence_e'($urandom_range(3))));
    end
  endfunction

  // -------------------------------------------------------------------------
  // Clock and response side
  // -------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: decide at the rising edge, drive ready at the falling edge
  initial begin : rsp_sink
    bit next_ready;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = ($urandom_range(99) >= recv_stall_pct);
      end
      @(negedge clk_i);
      rsp_ch.ready = next_ready;
    end
  end

  task automatic note_bad_response(string what, rsp_item_t want, rsp_item_t got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t: %s: exp value=%h st=%0d ovf=%0d pos=%0d, got value=%h st=%0d ovf=%0d pos=%0d",
               $realtime, what, want.read_value, want.status, want.overflow, want.bit_position,
               got.read_value, got.status, got.overflow, got.bit_position);
    end
  endtask

  // Response check, request prediction, config tracking, activity count
  always @(posedge clk_i) begin : scoreboard
    rsp_item_t got, want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        moved = 1'b1;
        got   = '{rsp_ch.read_value, rsp_ch.status, rsp_ch.overflow, rsp_ch.bit_position};
        if (awaited_rsp_q.size() == 0) begin
          note_bad_response("response with no request pending", '0, got);
        end else begin
          want = awaited_rsp_q.pop_front();
          if (got !== want) note_bad_response("response mismatch", want, got);
        end
      end
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
        moved = 1'b1;
        want  = predict_response(cur_req);
        if (cur_has_known) want = cur_known_rsp;
        awaited_rsp_q.push_back(want);
      end
      if (cfg_we) length_image = cfg_wdata;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog on a stuck handshake
  initial begin : watchdog
    @(negedge clk_i);
    while (quiet_cycles < WATCHDOG_CYCLES) @(negedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Request side (entered and left just after a falling edge)
  // -------------------------------------------------------------------------
  task automatic offer_request(req_item_t rq, bit has_known, rsp_item_t known_rsp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    cur_req         = rq;
    cur_has_known   = has_known;
    cur_known_rsp   = known_rsp;
    req_ch.req_type = rq.req_type;
    req_ch.value    = rq.value;
    req_ch.num_bits = rq.num_bits;
    req_ch.position = rq.position;
    req_ch.whence   = rq.whence;
    req_ch.valid    = 1'b1;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    req_ch.valid = 1'b0;
    while (awaited_rsp_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_usable_length(logic [15:0] len);
    cfg_we    = 1'b1;
    cfg_wdata = len;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  initial begin : main_seq
    req_item_t   rq;
    int unsigned sent;
    bit          paused;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 16'h0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_WR_U;
    req_ch.value    = 32'h0;
    req_ch.num_bits = 6'd0;
    req_ch.position = 18'sd0;
    req_ch.whence   = WH_START;
    cur_req         = '0;
    cur_has_known   = 1'b0;
    cur_known_rsp   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every word so later reads never see unwritten storage
    for (int w = 0; w < BUF_WORDS; w++) begin
      offer_request(make_req(REQ_WR_U, $urandom, 32, 0, WH_START), 1'b0, '0);
    end

    foreach (DIRECTED_ROWS[i]) begin
      offer_request(DIRECTED_ROWS[i].rq, DIRECTED_ROWS[i].has_known,
                    DIRECTED_ROWS[i].known_rsp);
    end
    wait_for_results();

    foreach (PHASES[p]) begin
      set_usable_length(PHASES[p].len);
      send_idle_pct  = PHASES[p].send_pct;
      recv_stall_pct = PHASES[p].recv_pct;
      if (PHASES[p].long_hold) hold_left = LONG_HOLD;
      planned_reqs_q.delete();
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASES[p].items) begin
        if (planned_reqs_q.size() == 0) plan_random_batch();
        rq = planned_reqs_q.pop_front();
        offer_request(rq, 1'b0, '0);
        if (rq.req_type != REQ_SPARE_6 && rq.req_type != REQ_SPARE_7) sent++;
        // sender pause mid-phase until everything has come back
        if (!paused && sent >= PHASES[p].items / 2) begin
          paused = 1'b1;
          wait_for_results();
        end
      end
      wait_for_results();
    end

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
